// ----- rtl/core/mlt_pkg.sv -----
// Shared types, codes and constants of the MAC learning table.
`default_nettype none
package mlt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned MAC_W      = 48;
  localparam int unsigned STAMP_W    = 48;
  localparam int unsigned PORT_W     = 8;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_LEARN      = 3'd0,
    CMD_LOOKUP     = 3'd1,
    CMD_BEGIN_LOAD = 3'd2,
    CMD_STAGE      = 3'd3,
    CMD_COMMIT     = 3'd4
  } cmd_e;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_AGED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_AGING_ENABLE    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AGING_THRESHOLD = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_COPY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [MAC_W-1:0]   mac_address;
    logic [STAMP_W-1:0] timestamp;
    logic [PORT_W-1:0]  egress_port;
  } in_beat_t;

  typedef struct packed {
    logic                hit;
    logic [PORT_W-1:0]   port_out;
    logic [STATUS_W-1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
    logic [PORT_W-1:0]  port;
  } oper_entry_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } admin_entry_t;

  typedef struct packed {
    logic eq;
    logic aged;
  } alu_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/mlt_ram.sv -----
// Single-port-write, registered-read table memory.
`default_nettype none
module mlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/mlt_alu.sv -----
// Shared key compare and age check unit.
`default_nettype none
module mlt_alu (
  input  wire logic [mlt_pkg::STAMP_W-1:0] a_i,
  input  wire logic [mlt_pkg::STAMP_W-1:0] b_i,
  input  wire logic [mlt_pkg::STAMP_W-1:0] thr_i,
  output mlt_pkg::alu_res_t                res_o
);
  import mlt_pkg::*;

  logic [STAMP_W:0] diff;

  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.eq   = (a_i == b_i);
  assign res_o.aged = !diff[STAMP_W] && (diff[STAMP_W-1:0] >= thr_i);

endmodule
`default_nettype wire

// ----- rtl/core/mac_learning_table_with_aging_unit.sv -----
// Top level of the MAC learning table with aging and staged static load.
//
// One command is taken at a time and yields one result beat. Learn, lookup
// and stage scan the table one slot per cycle through a registered memory
// read and one shared compare unit: a scan stops at the slot that holds
// the key, and a miss reads every slot. Commit with a load pending sweeps
// the staged memory into the operational memory one slot per cycle; begin
// load and other commands go straight to the result. The scan length, set
// by the single memory read port, fixes the rate. Valid bits are flip-flops
// cleared by reset, so no clearing pass is needed. A finished result waits
// in the output register while the next command is accepted.
`default_nettype none
module mac_learning_table_with_aging_unit #(
  parameter int unsigned TableEntries = mlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  mlt_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output mlt_pkg::out_beat_t              out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [mlt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [mlt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mlt_pkg::*;

  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam int unsigned CntW  = AddrW + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TableEntries - 1);
  localparam logic [CntW-1:0]  CntEnd   = CntW'(TableEntries);

  state_e state_q, state_d;
  in_beat_t item_q, item_d;
  out_beat_t res_q, res_d;
  out_beat_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic pipe_v_q, pipe_v_d;
  logic [AddrW-1:0] pipe_addr_q, pipe_addr_d;
  logic found_q, found_d;
  logic [AddrW-1:0] slot_q, slot_d;
  logic free_found_q, free_found_d;
  logic [AddrW-1:0] free_q, free_d;
  oper_entry_t entry_q, entry_d;
  logic [TableEntries-1:0] oper_valid_q, oper_valid_d;
  logic [TableEntries-1:0] admin_valid_q, admin_valid_d;
  logic load_pending_q, load_pending_d;
  logic aging_enable_q;
  logic [STAMP_W-1:0] aging_threshold_q;

  logic oper_we, admin_we;
  logic [AddrW-1:0] oper_waddr, admin_waddr, rd_addr;
  oper_entry_t oper_wdata, oper_rd;
  admin_entry_t admin_wdata, admin_rd;
  logic [STAMP_W-1:0] alu_a, alu_b;
  alu_res_t alu_res;
  logic is_stage, vbit, in_acc;

  mlt_ram #(.Width($bits(oper_entry_t)), .Depth(TableEntries)) u_oper_ram (
    .clk_i   (clk_i),
    .we_i    (oper_we),
    .waddr_i (oper_waddr),
    .wdata_i (oper_wdata),
    .raddr_i (rd_addr),
    .rdata_o (oper_rd)
  );

  mlt_ram #(.Width($bits(admin_entry_t)), .Depth(TableEntries)) u_admin_ram (
    .clk_i   (clk_i),
    .we_i    (admin_we),
    .waddr_i (admin_waddr),
    .wdata_i (admin_wdata),
    .raddr_i (rd_addr),
    .rdata_o (admin_rd)
  );

  mlt_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .thr_i (aging_threshold_q),
    .res_o (alu_res)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_stage    = (item_q.command == CMD_STAGE);
  assign rd_addr     = cnt_q[AddrW-1:0];
  assign vbit        = is_stage ? admin_valid_q[pipe_addr_q] : oper_valid_q[pipe_addr_q];

  always_comb begin
    if (state_q == ST_SCAN) begin
      alu_a = item_q.mac_address;
      alu_b = is_stage ? admin_rd.mac : oper_rd.mac;
    end else begin
      alu_a = item_q.timestamp;
      alu_b = entry_q.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_enable_q    <= 1'b0;
      aging_threshold_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_AGING_ENABLE:    aging_enable_q    <= cfg_wdata_i[0];
        REG_AGING_THRESHOLD: aging_threshold_q <= cfg_wdata_i[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      oper_valid_q   <= '0;
      admin_valid_q  <= '0;
      load_pending_q <= 1'b0;
      pipe_v_q       <= 1'b0;
      found_q        <= 1'b0;
      free_found_q   <= 1'b0;
      cnt_q          <= '0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      oper_valid_q   <= oper_valid_d;
      admin_valid_q  <= admin_valid_d;
      load_pending_q <= load_pending_d;
      pipe_v_q       <= pipe_v_d;
      found_q        <= found_d;
      free_found_q   <= free_found_d;
      cnt_q          <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    res_q       <= res_d;
    out_q       <= out_d;
    pipe_addr_q <= pipe_addr_d;
    slot_q      <= slot_d;
    free_q      <= free_d;
    entry_q     <= entry_d;
  end

  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cnt_d          = cnt_q;
    pipe_v_d       = 1'b0;
    pipe_addr_d    = pipe_addr_q;
    found_d        = found_q;
    slot_d         = slot_q;
    free_found_d   = free_found_q;
    free_d         = free_q;
    entry_d        = entry_q;
    oper_valid_d   = oper_valid_q;
    admin_valid_d  = admin_valid_q;
    load_pending_d = load_pending_q;
    oper_we        = 1'b0;
    oper_waddr     = slot_q;
    oper_wdata     = '{mac: item_q.mac_address, stamp: item_q.timestamp,
                       port: item_q.egress_port};
    admin_we       = 1'b0;
    admin_waddr    = free_q;
    admin_wdata    = '{mac: item_q.mac_address, port: item_q.egress_port};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d       = in_data_i;
          res_d        = '0;
          cnt_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          case (in_data_i.command)
            CMD_LEARN, CMD_LOOKUP, CMD_STAGE: state_d = ST_SCAN;
            CMD_BEGIN_LOAD: begin
              admin_valid_d  = '0;
              load_pending_d = 1'b1;
              state_d        = ST_DONE;
            end
            CMD_COMMIT: state_d = load_pending_q ? ST_COPY : ST_DONE;
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        if (cnt_q < CntEnd) begin
          pipe_v_d    = 1'b1;
          pipe_addr_d = cnt_q[AddrW-1:0];
          cnt_d       = cnt_q + 1'b1;
        end
        if (pipe_v_q) begin
          if (vbit && alu_res.eq) begin
            found_d = 1'b1;
            slot_d  = pipe_addr_q;
            entry_d = oper_rd;
            state_d = ST_DECIDE;
          end else begin
            if (!vbit && !free_found_q) begin
              free_found_d = 1'b1;
              free_d       = pipe_addr_q;
            end
            if (pipe_addr_q == LastAddr) begin
              state_d = ST_DECIDE;
            end
          end
        end
      end

      ST_DECIDE: begin
        state_d = ST_DONE;
        case (item_q.command)
          CMD_LEARN: begin
            if (found_q) begin
              oper_we = 1'b1;
            end else if (free_found_q) begin
              oper_we              = 1'b1;
              oper_waddr           = free_q;
              oper_valid_d[free_q] = 1'b1;
            end else begin
              res_d.status = STATUS_FULL;
            end
          end
          CMD_LOOKUP: begin
            if (!found_q) begin
              res_d.status = STATUS_MISS;
            end else if (aging_enable_q && (entry_q.stamp != '0) && alu_res.aged) begin
              oper_valid_d[slot_q] = 1'b0;
              res_d.status         = STATUS_AGED;
            end else begin
              res_d.hit      = 1'b1;
              res_d.port_out = entry_q.port;
              oper_wdata     = '{mac: entry_q.mac, stamp: item_q.timestamp,
                                 port: entry_q.port};
              oper_we        = (entry_q.stamp != '0);
            end
          end
          CMD_STAGE: begin
            if (!found_q) begin
              if (free_found_q) begin
                admin_we              = 1'b1;
                admin_valid_d[free_q] = 1'b1;
              end else begin
                res_d.status = STATUS_FULL;
              end
            end
          end
          default: ;
        endcase
      end

      ST_COPY: begin
        if (cnt_q < CntEnd) begin
          pipe_v_d    = 1'b1;
          pipe_addr_d = cnt_q[AddrW-1:0];
          cnt_d       = cnt_q + 1'b1;
        end
        if (pipe_v_q) begin
          oper_we    = 1'b1;
          oper_waddr = pipe_addr_q;
          oper_wdata = '{mac: admin_rd.mac, stamp: '0, port: admin_rd.port};
          if (pipe_addr_q == LastAddr) begin
            oper_valid_d   = admin_valid_q;
            admin_valid_d  = '0;
            load_pending_d = 1'b0;
            state_d        = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block took a beat without going busy");

  a_copy_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> load_pending_q)
    else $error("commit sweep without a pending load");

  a_hit_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> (out_data_o.status == STATUS_OK))
    else $error("hit reported with error status");

  a_miss_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |-> (out_data_o.port_out == '0))
    else $error("nonzero port without a hit");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench of the MAC learning table: directed and random commands checked against a table model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlt_pkg::*;

  localparam int TBL         = TABLE_ENTRIES_DEF;
  localparam int POOL        = 12;
  localparam int PHASE_ITEMS = 170;
  localparam int LONG_HOLD   = 400;
  localparam int IDLE_GAP    = 8;
  localparam int END_WAIT    = 80;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [47:0] MAC_ONES = '1;
  localparam logic [47:0] TS_MAX   = '1;
  localparam logic [47:0] MAC_A    = 48'h0123_4567_89AB;
  localparam logic [47:0] MAC_B    = 48'h00A0_C9FF_1234;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  mac_learning_table_with_aging_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  in_beat_t    cmd_queue[$];
  out_beat_t   exp_results[$];
  int          n_queued       = 0;
  int          n_checked      = 0;
  int          err_cnt        = 0;
  int          phase_items    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_cnt       = 0;
  logic        hold_arm       = 1'b0;
  int          cycle_cnt      = 0;
  logic [47:0] now_ts         = 48'd1000;
  logic [47:0] mac_pool[POOL];

  // table model state
  bit          age_en;
  logic [47:0] age_thr;
  bit          op_vld[TBL];
  logic [47:0] op_mac[TBL];
  logic [47:0] op_stamp[TBL];
  logic [7:0]  op_port[TBL];
  bit          st_vld[TBL];
  logic [47:0] st_mac[TBL];
  logic [7:0]  st_port[TBL];
  bit          load_armed;

  function automatic int slot_of(input bit staged, input logic [47:0] key);
    for (int i = 0; i < TBL; i++) begin
      if (staged ? (st_vld[i] && st_mac[i] == key) : (op_vld[i] && op_mac[i] == key)) return i;
    end
    return -1;
  endfunction

  function automatic int free_of(input bit staged);
    for (int i = 0; i < TBL; i++) begin
      if (!(staged ? st_vld[i] : op_vld[i])) return i;
    end
    return -1;
  endfunction

  function automatic out_beat_t forward_table_step(input in_beat_t b);
    out_beat_t   res;
    int          s;
    logic [47:0] stored;
    res = '0;
    case (b.command)
      CMD_LEARN: begin
        s = slot_of(1'b0, b.mac_address);
        if (s < 0) s = free_of(1'b0);
        if (s < 0) begin
          res.status = STATUS_FULL;
        end else begin
          op_vld[s]   = 1'b1;
          op_mac[s]   = b.mac_address;
          op_stamp[s] = b.timestamp;
          op_port[s]  = b.egress_port;
        end
      end
      CMD_LOOKUP: begin
        s = slot_of(1'b0, b.mac_address);
        if (s < 0) begin
          res.status = STATUS_MISS;
        end else begin
          stored = op_stamp[s];
          if (age_en && stored != '0 && b.timestamp >= stored &&
              (b.timestamp - stored) >= age_thr) begin
            op_vld[s]  = 1'b0;
            res.status = STATUS_AGED;
          end else begin
            res.hit      = 1'b1;
            res.port_out = op_port[s];
            if (stored != '0) op_stamp[s] = b.timestamp;
          end
        end
      end
      CMD_BEGIN_LOAD: begin
        for (int i = 0; i < TBL; i++) st_vld[i] = 1'b0;
        load_armed = 1'b1;
      end
      CMD_STAGE: begin
        if (slot_of(1'b1, b.mac_address) < 0) begin
          s = free_of(1'b1);
          if (s < 0) begin
            res.status = STATUS_FULL;
          end else begin
            st_vld[s]  = 1'b1;
            st_mac[s]  = b.mac_address;
            st_port[s] = b.egress_port;
          end
        end
      end
      CMD_COMMIT: begin
        if (load_armed) begin
          for (int i = 0; i < TBL; i++) begin
            op_vld[i]   = st_vld[i];
            op_mac[i]   = st_mac[i];
            op_stamp[i] = '0;
            op_port[i]  = st_port[i];
            st_vld[i]   = 1'b0;
          end
          load_armed = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        exp_results.push_back(forward_table_step(in_data_i));
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled beat
      end else if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= cmd_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_arm) begin
      hold_cnt <= LONG_HOLD;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        if (exp_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, expected none actual %h", $time, out_data_o);
        end else begin
          want = exp_results.pop_front();
          if (out_data_o.hit !== want.hit) begin
            err_cnt++;
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, out_data_o.hit);
          end
          if (out_data_o.port_out !== want.port_out) begin
            err_cnt++;
            $display("%0t: port_out expected %0d actual %0d", $time, want.port_out,
                     out_data_o.port_out);
          end
          if (out_data_o.status !== want.status) begin
            err_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data_o.status);
          end
        end
      end
      out_stall_i <= (hold_cnt != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic [7:0] rand_port();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [47:0] pick_mac();
    return ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL - 1)] : rand48();
  endfunction

  function automatic logic [47:0] next_ts();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return rand48();
    if (r < 15) return now_ts - 48'($urandom_range(1, 20));
    now_ts = now_ts + 48'($urandom_range(0, 12));
    return now_ts;
  endfunction

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [47:0] mac,
                          input logic [47:0] ts, input logic [7:0] port);
    in_beat_t b;
    b.command     = cmd;
    b.mac_address = mac;
    b.timestamp   = ts;
    b.egress_port = port;
    cmd_queue.push_back(b);
    n_queued++;
    if (cmd <= CMD_COMMIT) phase_items++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_AGING_ENABLE) begin
      age_en = val[0];
    end else begin
      age_thr = val;
    end
  endtask

  task automatic wait_idle(input int gap);
    while (n_checked < n_queued) @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic gen_sequence();
    int          r;
    logic [47:0] m;
    logic [47:0] t;
    r = $urandom_range(99);
    if (r < 30) begin
      repeat ($urandom_range(1, 4)) push_cmd(CMD_LEARN, pick_mac(), next_ts(), rand_port());
      repeat ($urandom_range(1, 3)) begin
        push_cmd(CMD_LOOKUP, mac_pool[$urandom_range(POOL - 1)], next_ts(), rand_port());
      end
    end else if (r < 55) begin
      repeat ($urandom_range(1, 5)) push_cmd(CMD_LOOKUP, pick_mac(), next_ts(), rand_port());
    end else if (r < 70) begin
      push_cmd(CMD_BEGIN_LOAD, rand48(), rand48(), rand_port());
      repeat ($urandom_range(1, 8)) push_cmd(CMD_STAGE, pick_mac(), rand48(), rand_port());
      if ($urandom_range(99) < 80) push_cmd(CMD_COMMIT, rand48(), rand48(), rand_port());
    end else if (r < 80) begin
      repeat ($urandom_range(1, 3)) begin
        push_cmd(CMD_W'($urandom_range(7)), rand48(), rand48(), rand_port());
      end
    end else if (r < 85) begin
      push_cmd($urandom_range(1) ? CMD_COMMIT : CMD_STAGE, pick_mac(), next_ts(), rand_port());
    end else begin
      // land the lookup right around the aging threshold
      m = pick_mac();
      t = next_ts();
      push_cmd(CMD_LEARN, m, t, rand_port());
      push_cmd(CMD_LOOKUP, m, t + age_thr - 48'd1 + 48'($urandom_range(2)), rand_port());
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit en,
                           input logic [47:0] thr, input bit pressure);
    wait_idle(IDLE_GAP);
    write_reg(REG_AGING_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_AGING_THRESHOLD, thr);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    phase_items    = 0;
    if (pressure) begin
      hold_arm <= 1'b1;
      @(posedge clk_i);
      hold_arm <= 1'b0;
      // overflow the learned table, then the staged one
      repeat (TBL + 2) push_cmd(CMD_LEARN, rand48(), next_ts(), rand_port());
      push_cmd(CMD_BEGIN_LOAD, rand48(), rand48(), rand_port());
      repeat (TBL + 1) push_cmd(CMD_STAGE, rand48(), '0, rand_port());
      push_cmd(CMD_COMMIT, rand48(), rand48(), rand_port());
      push_cmd(CMD_LEARN, rand48(), next_ts(), rand_port());
    end
    while (phase_items < PHASE_ITEMS) gen_sequence();
  endtask

  initial begin
    age_en     = 1'b0;
    age_thr    = '0;
    load_armed = 1'b0;
    for (int i = 0; i < TBL; i++) begin
      op_vld[i] = 1'b0;
      st_vld[i] = 1'b0;
    end
    mac_pool[0] = '0;
    mac_pool[1] = MAC_ONES;
    for (int i = 2; i < POOL; i++) mac_pool[i] = rand48();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_AGING_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_AGING_THRESHOLD, CFG_DATA_W'(10));
    push_cmd(CMD_LOOKUP, '0, 48'd1, 8'd0);
    push_cmd(CMD_LEARN, '0, 48'd100, 8'd0);
    push_cmd(CMD_LEARN, MAC_ONES, TS_MAX, 8'hFF);
    push_cmd(CMD_LOOKUP, '0, 48'd105, 8'd0);
    push_cmd(CMD_LOOKUP, '0, 48'd115, 8'd0);
    push_cmd(CMD_LOOKUP, '0, 48'd116, 8'd0);
    push_cmd(CMD_LEARN, MAC_A, '0, 8'd7);
    push_cmd(CMD_LOOKUP, MAC_A, TS_MAX, 8'd0);
    push_cmd(CMD_LOOKUP, MAC_ONES, 48'd5, 8'd0);
    push_cmd(CMD_LEARN, MAC_A, 48'd50, 8'd9);
    push_cmd(CMD_LOOKUP, MAC_A, 48'd55, 8'd0);
    push_cmd(CMD_LOOKUP, MAC_A, '0, 8'd0);
    push_cmd(CMD_LOOKUP, MAC_A, TS_MAX, 8'd0);
    push_cmd(CMD_COMMIT, '0, '0, 8'd0);
    push_cmd(CMD_STAGE, MAC_B, '0, 8'd3);
    push_cmd(CMD_BEGIN_LOAD, '0, '0, 8'd0);
    push_cmd(CMD_STAGE, MAC_B, '0, 8'd4);
    push_cmd(CMD_STAGE, MAC_B, '0, 8'd5);
    push_cmd(CMD_STAGE, MAC_ONES, '0, 8'hFF);
    push_cmd(CMD_COMMIT, '0, '0, 8'd0);
    push_cmd(CMD_LOOKUP, MAC_B, 48'd20, 8'd0);
    push_cmd(CMD_LOOKUP, MAC_A, 48'd20, 8'd0);
    for (int c = CMD_COMMIT + 1; c < (1 << CMD_W); c++) begin
      push_cmd(CMD_W'(c), rand48(), rand48(), rand_port());
    end
    push_cmd(CMD_COMMIT, MAC_ONES, TS_MAX, 8'hFF);

    run_phase(0, 0, 1'b1, 48'd30, 1'b0);
    run_phase(74, 0, 1'b0, TS_MAX, 1'b0);
    run_phase(0, 74, 1'b1, '0, 1'b0);
    run_phase(10, 10, 1'b1, TS_MAX, 1'b1);
    run_phase(0, 0, 1'b1, rand48(), 1'b0);

    wait_idle(END_WAIT);
    if (exp_results.size() != 0) begin
      err_cnt += exp_results.size();
      $display("%0t: %0d expected beats never arrived", $time, exp_results.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mlt_pkg.sv
rtl/core/mlt_ram.sv
rtl/core/mlt_alu.sv
rtl/core/mac_learning_table_with_aging_unit.sv
sim/tb_top.sv
